// ===== hdl/cpu8_register_alu_execute_defines.svh =====
// Assertion macros for the 8-bit CPU execute unit.
// Each macro expects a clk and an arst_n in the scope where it is used.
`ifndef CPU8_REGISTER_ALU_EXECUTE_DEFINES_SVH
`define CPU8_REGISTER_ALU_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define C8EX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define C8EX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/c8ex_pkg.sv =====
// Shared types, operation codes and helpers of the 8-bit CPU execute unit.
// No dependencies.
package c8ex_pkg;

	// Decoded operation codes; codes above NOP behave as NOP
	typedef enum logic [5:0] {
		CMD_ADC = 6'd0, CMD_SBC, CMD_AND, CMD_ORA, CMD_EOR, CMD_BIT,
		CMD_CMP, CMD_CPX, CMD_CPY,
		CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR,
		CMD_INC, CMD_DEC, CMD_INX, CMD_INY, CMD_DEX, CMD_DEY,
		CMD_LDA, CMD_LDX, CMD_LDY, CMD_STA, CMD_STX, CMD_STY,
		CMD_TAX, CMD_TAY, CMD_TSX, CMD_TXA, CMD_TXS, CMD_TYA,
		CMD_CLC, CMD_CLD, CMD_CLI, CMD_CLV, CMD_SEC, CMD_SED, CMD_SEI,
		CMD_BCC, CMD_BCS, CMD_BEQ, CMD_BMI, CMD_BNE, CMD_BPL, CMD_BVC, CMD_BVS,
		CMD_PHA, CMD_PHP, CMD_PLA, CMD_PLP, CMD_NOP
	} cmd_t;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] PHP_B_MASK = 8'h10;

	typedef struct packed {
		logic n;
		logic v;
		logic d;
		logic i;
		logic z;
		logic c;
	} flags_t;

	// Architectural registers
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		flags_t     flags;
	} arch_t;

	// One input beat
	typedef struct packed {
		logic [5:0] cmd;
		logic [7:0] operand;
		logic       use_acc;
	} item_t;

	// Side outputs of one operation (memory/stack access and branch)
	typedef struct packed {
		logic       write_enable;
		logic [7:0] write_data;
		logic       stack_access;
		logic [7:0] stack_offset;
		logic       branch_taken;
	} side_t;

	// N V 1 B D I Z C with B read as 0
	function automatic logic [7:0] pack_status(flags_t f);
		return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
	endfunction

endpackage

// ===== hdl/c8ex_if.sv =====
// Valid/ready channel interfaces of the 8-bit CPU execute unit:
// the decoded-operation input channel and the result channel. No dependencies.
interface c8ex_item_if;
	logic       valid;
	logic       ready;
	logic [5:0] cmd;
	logic [7:0] operand;
	logic       use_acc;

	modport source (output valid, output cmd, output operand, output use_acc, input ready);
	modport sink (input valid, input cmd, input operand, input use_acc, output ready);
endinterface

interface c8ex_result_if;
	logic       valid;
	logic       ready;
	logic       write_enable;
	logic [7:0] write_data;
	logic       stack_access;
	logic [7:0] stack_offset;
	logic       branch_taken;
	logic [7:0] acc_out;
	logic [7:0] x_out;
	logic [7:0] y_out;
	logic [7:0] status_out;

	modport source (
		output valid, output write_enable, output write_data, output stack_access,
		output stack_offset, output branch_taken, output acc_out, output x_out,
		output y_out, output status_out, input ready
	);
	modport sink (
		input valid, input write_enable, input write_data, input stack_access,
		input stack_offset, input branch_taken, input acc_out, input x_out,
		input y_out, input status_out, output ready
	);
endinterface

// ===== hdl/c8ex_alu.sv =====
// Combinational execute logic: next registers, flags and side outputs of one operation.
// Depends on c8ex_pkg.
module c8ex_alu (
	input  c8ex_pkg::item_t item,
	input  c8ex_pkg::arch_t cur,
	output c8ex_pkg::arch_t nxt,
	output c8ex_pkg::side_t side
);

	logic [7:0]        opd;
	logic              cin;

	// binary add, also SBC with the operand inverted
	logic [7:0]        bin_b;
	logic [8:0]        bin_sum;
	logic              bin_v;

	// decimal add
	logic [4:0]        dadd_lo;
	logic [4:0]        dadd_lo_p6;
	logic [4:0]        dadd_lo_adj;
	logic [9:0]        dadd_raw;
	logic [9:0]        dadd_sum;

	// decimal subtract
	logic signed [5:0]  dsub_lo;
	logic signed [5:0]  dsub_lo_m6;
	logic signed [5:0]  dsub_lo_adj;
	logic signed [10:0] dsub_raw;
	logic signed [10:0] dsub_diff;

	// compares
	logic [7:0]        cmp_reg;
	logic [8:0]        cmp_diff;

	// shifts and rotates
	logic [7:0]        sh_in;
	logic [7:0]        sh_out;
	logic              sh_c;

	logic [7:0]        inc_v;
	logic [7:0]        dec_v;

	function automatic c8ex_pkg::flags_t with_nz(c8ex_pkg::flags_t f, logic [7:0] v);
		c8ex_pkg::flags_t r;
		r   = f;
		r.n = v[7];
		r.z = (v == 8'h00);
		return r;
	endfunction

	assign opd = item.operand;
	assign cin = cur.flags.c;

	// Binary ADC/SBC
	assign bin_b   = (item.cmd == c8ex_pkg::CMD_SBC) ? ~opd : opd;
	assign bin_sum = {1'b0, cur.a} + {1'b0, bin_b} + {8'h00, cin};
	assign bin_v   = ~(cur.a[7] ^ bin_b[7]) & (bin_sum[7] ^ bin_b[7]);

	// Decimal ADC: +6 on a low digit of ten or more, +0x60 on a sum of 0xA0 or more
	assign dadd_lo     = {1'b0, cur.a[3:0]} + {1'b0, opd[3:0]} + {4'h0, cin};
	assign dadd_lo_p6  = dadd_lo + 5'd6;
	assign dadd_lo_adj = (dadd_lo >= 5'd10) ? {1'b1, dadd_lo_p6[3:0]} : dadd_lo;
	assign dadd_raw    = {2'b00, cur.a[7:4], 4'h0} + {2'b00, opd[7:4], 4'h0}
		+ {5'h00, dadd_lo_adj};
	assign dadd_sum    = (dadd_raw >= 10'h0A0) ? dadd_raw + 10'h060 : dadd_raw;

	// Decimal SBC: borrow adjust per digit, V untouched
	assign dsub_lo     = $signed({2'b00, cur.a[3:0]}) - $signed({2'b00, opd[3:0]})
		- $signed({5'h00, ~cin});
	assign dsub_lo_m6  = dsub_lo - 6'sd6;
	assign dsub_lo_adj = dsub_lo[5] ? $signed({2'b11, dsub_lo_m6[3:0]}) : dsub_lo;
	assign dsub_raw    = $signed({3'b000, cur.a[7:4], 4'h0})
		- $signed({3'b000, opd[7:4], 4'h0})
		+ $signed({{5{dsub_lo_adj[5]}}, dsub_lo_adj});
	assign dsub_diff   = dsub_raw[10] ? dsub_raw - 11'sd96 : dsub_raw;

	// Compare against A, X or Y
	always_comb begin
		case (item.cmd)
			c8ex_pkg::CMD_CPX: cmp_reg = cur.x;
			c8ex_pkg::CMD_CPY: cmp_reg = cur.y;
			default:           cmp_reg = cur.a;
		endcase
	end
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, opd};

	// Shift unit, accumulator or memory operand
	always_comb begin
		sh_in = item.use_acc ? cur.a : opd;
		if (item.cmd == c8ex_pkg::CMD_ASL || item.cmd == c8ex_pkg::CMD_ROL) begin
			sh_c   = sh_in[7];
			sh_out = {sh_in[6:0], (item.cmd == c8ex_pkg::CMD_ROL) & cin};
		end else begin
			sh_c   = sh_in[0];
			sh_out = {(item.cmd == c8ex_pkg::CMD_ROR) & cin, sh_in[7:1]};
		end
	end

	assign inc_v = opd + 8'd1;
	assign dec_v = opd - 8'd1;

	// Operation decode
	always_comb begin
		nxt  = cur;
		side = '0;
		unique case (item.cmd) inside
			c8ex_pkg::CMD_ADC: begin
				if (cur.flags.d) begin
					nxt.a       = dadd_sum[7:0];
					nxt.flags   = with_nz(cur.flags, dadd_sum[7:0]);
					nxt.flags.c = (dadd_sum >= 10'h100);
					nxt.flags.v = (dadd_sum > 10'd127);
				end else begin
					nxt.a       = bin_sum[7:0];
					nxt.flags   = with_nz(cur.flags, bin_sum[7:0]);
					nxt.flags.c = bin_sum[8];
					nxt.flags.v = bin_v;
				end
			end
			c8ex_pkg::CMD_SBC: begin
				if (cur.flags.d) begin
					nxt.a       = dsub_diff[7:0];
					nxt.flags   = with_nz(cur.flags, dsub_diff[7:0]);
					nxt.flags.c = ~dsub_diff[10];
				end else begin
					nxt.a       = bin_sum[7:0];
					nxt.flags   = with_nz(cur.flags, bin_sum[7:0]);
					nxt.flags.c = bin_sum[8];
					nxt.flags.v = bin_v;
				end
			end
			c8ex_pkg::CMD_AND: begin
				nxt.a     = cur.a & opd;
				nxt.flags = with_nz(cur.flags, cur.a & opd);
			end
			c8ex_pkg::CMD_ORA: begin
				nxt.a     = cur.a | opd;
				nxt.flags = with_nz(cur.flags, cur.a | opd);
			end
			c8ex_pkg::CMD_EOR: begin
				nxt.a     = cur.a ^ opd;
				nxt.flags = with_nz(cur.flags, cur.a ^ opd);
			end
			c8ex_pkg::CMD_BIT: begin
				nxt.flags.z = ((cur.a & opd) == 8'h00);
				nxt.flags.n = opd[7];
				nxt.flags.v = opd[6];
			end
			c8ex_pkg::CMD_CMP, c8ex_pkg::CMD_CPX, c8ex_pkg::CMD_CPY: begin
				nxt.flags.c = ~cmp_diff[8];
				nxt.flags.z = (cmp_diff[7:0] == 8'h00);
				nxt.flags.n = cmp_diff[7];
			end
			c8ex_pkg::CMD_ASL, c8ex_pkg::CMD_LSR, c8ex_pkg::CMD_ROL, c8ex_pkg::CMD_ROR: begin
				nxt.flags   = with_nz(cur.flags, sh_out);
				nxt.flags.c = sh_c;
				if (item.use_acc) begin
					nxt.a = sh_out;
				end else begin
					side.write_enable = 1'b1;
					side.write_data   = sh_out;
				end
			end
			c8ex_pkg::CMD_INC: begin
				nxt.flags         = with_nz(cur.flags, inc_v);
				side.write_enable = 1'b1;
				side.write_data   = inc_v;
			end
			c8ex_pkg::CMD_DEC: begin
				nxt.flags         = with_nz(cur.flags, dec_v);
				side.write_enable = 1'b1;
				side.write_data   = dec_v;
			end
			c8ex_pkg::CMD_INX: begin
				nxt.x     = cur.x + 8'd1;
				nxt.flags = with_nz(cur.flags, cur.x + 8'd1);
			end
			c8ex_pkg::CMD_INY: begin
				nxt.y     = cur.y + 8'd1;
				nxt.flags = with_nz(cur.flags, cur.y + 8'd1);
			end
			c8ex_pkg::CMD_DEX: begin
				nxt.x     = cur.x - 8'd1;
				nxt.flags = with_nz(cur.flags, cur.x - 8'd1);
			end
			c8ex_pkg::CMD_DEY: begin
				nxt.y     = cur.y - 8'd1;
				nxt.flags = with_nz(cur.flags, cur.y - 8'd1);
			end
			c8ex_pkg::CMD_LDA: begin
				nxt.a     = opd;
				nxt.flags = with_nz(cur.flags, opd);
			end
			c8ex_pkg::CMD_LDX: begin
				nxt.x     = opd;
				nxt.flags = with_nz(cur.flags, opd);
			end
			c8ex_pkg::CMD_LDY: begin
				nxt.y     = opd;
				nxt.flags = with_nz(cur.flags, opd);
			end
			c8ex_pkg::CMD_STA: begin
				side.write_enable = 1'b1;
				side.write_data   = cur.a;
			end
			c8ex_pkg::CMD_STX: begin
				side.write_enable = 1'b1;
				side.write_data   = cur.x;
			end
			c8ex_pkg::CMD_STY: begin
				side.write_enable = 1'b1;
				side.write_data   = cur.y;
			end
			c8ex_pkg::CMD_TAX: begin
				nxt.x     = cur.a;
				nxt.flags = with_nz(cur.flags, cur.a);
			end
			c8ex_pkg::CMD_TAY: begin
				nxt.y     = cur.a;
				nxt.flags = with_nz(cur.flags, cur.a);
			end
			c8ex_pkg::CMD_TSX: begin
				nxt.x     = cur.sp;
				nxt.flags = with_nz(cur.flags, cur.sp);
			end
			c8ex_pkg::CMD_TXA: begin
				nxt.a     = cur.x;
				nxt.flags = with_nz(cur.flags, cur.x);
			end
			c8ex_pkg::CMD_TXS: nxt.sp = cur.x;
			c8ex_pkg::CMD_TYA: begin
				nxt.a     = cur.y;
				nxt.flags = with_nz(cur.flags, cur.y);
			end
			c8ex_pkg::CMD_CLC: nxt.flags.c = 1'b0;
			c8ex_pkg::CMD_CLD: nxt.flags.d = 1'b0;
			c8ex_pkg::CMD_CLI: nxt.flags.i = 1'b0;
			c8ex_pkg::CMD_CLV: nxt.flags.v = 1'b0;
			c8ex_pkg::CMD_SEC: nxt.flags.c = 1'b1;
			c8ex_pkg::CMD_SED: nxt.flags.d = 1'b1;
			c8ex_pkg::CMD_SEI: nxt.flags.i = 1'b1;
			c8ex_pkg::CMD_BCC: side.branch_taken = ~cur.flags.c;
			c8ex_pkg::CMD_BCS: side.branch_taken = cur.flags.c;
			c8ex_pkg::CMD_BEQ: side.branch_taken = cur.flags.z;
			c8ex_pkg::CMD_BMI: side.branch_taken = cur.flags.n;
			c8ex_pkg::CMD_BNE: side.branch_taken = ~cur.flags.z;
			c8ex_pkg::CMD_BPL: side.branch_taken = ~cur.flags.n;
			c8ex_pkg::CMD_BVC: side.branch_taken = ~cur.flags.v;
			c8ex_pkg::CMD_BVS: side.branch_taken = cur.flags.v;
			// push: write at SP, then SP decrements
			c8ex_pkg::CMD_PHA, c8ex_pkg::CMD_PHP: begin
				side.write_enable = 1'b1;
				side.stack_access = 1'b1;
				side.stack_offset = cur.sp;
				side.write_data   = (item.cmd == c8ex_pkg::CMD_PHA) ? cur.a
					: (c8ex_pkg::pack_status(cur.flags) | c8ex_pkg::PHP_B_MASK);
				nxt.sp            = cur.sp - 8'd1;
			end
			// pull: SP increments first, the access goes to the new SP
			c8ex_pkg::CMD_PLA, c8ex_pkg::CMD_PLP: begin
				nxt.sp            = cur.sp + 8'd1;
				side.stack_access = 1'b1;
				side.stack_offset = cur.sp + 8'd1;
				if (item.cmd == c8ex_pkg::CMD_PLA) begin
					nxt.a     = opd;
					nxt.flags = with_nz(cur.flags, opd);
				end else begin
					nxt.flags = '{n: opd[7], v: opd[6], d: opd[3], i: opd[2],
						z: opd[1], c: opd[0]};
				end
			end
			// NOP and unused codes
			default: begin
				nxt  = cur;
				side = '0;
			end
		endcase
	end

endmodule

// ===== hdl/cpu8_register_alu_execute.sv =====
// An accepted operation beat goes through the input register, then the result register.
// Throughput: one operation per cycle unless a full result stage stalls on result.ready; the
// execute logic between the two registers updates A, X, Y, SP and flags.
// Reset (arst_n low, asynchronous): A, X, Y and flags clear, SP = 0xFD,
// both stages empty.
// Depends on c8ex_pkg, c8ex_if, c8ex_alu and cpu8_register_alu_execute_defines.svh.
`include "cpu8_register_alu_execute_defines.svh"

module cpu8_register_alu_execute (
	input  logic                 clk,
	input  logic                 arst_n,
	c8ex_item_if.sink            item,
	c8ex_result_if.source        result
);

	localparam c8ex_pkg::arch_t ARCH_RESET = '{
		a: 8'h00, x: 8'h00, y: 8'h00, sp: c8ex_pkg::SP_RESET, flags: '0
	};

	logic            v_s1;
	c8ex_pkg::item_t item_s1;
	logic            v_s2;
	c8ex_pkg::side_t side_s2;
	c8ex_pkg::arch_t arch_q;
	c8ex_pkg::arch_t arch_nxt;
	c8ex_pkg::side_t side_nxt;
	logic            advance;
	logic            in_ready;

	// Stage 1 moves into the result stage when that is empty or being drained
	assign advance  = v_s1 && (!v_s2 || result.ready);
	assign in_ready = !v_s1 || advance;
	assign item.ready = in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && item.valid) begin
			item_s1 <= '{cmd: item.cmd, operand: item.operand, use_acc: item.use_acc};
		end
	end

	c8ex_alu u_alu (
		.item (item_s1),
		.cur  (arch_q),
		.nxt  (arch_nxt),
		.side (side_nxt)
	);

	// Architectural registers commit as the operation enters the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= ARCH_RESET;
			v_s2   <= 1'b0;
		end else if (advance) begin
			arch_q <= arch_nxt;
			v_s2   <= 1'b1;
		end else if (result.ready) begin
			v_s2   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s2 <= side_nxt;
		end
	end

	// Result beat; registers always equal the state after the held operation
	assign result.valid        = v_s2;
	assign result.write_enable = side_s2.write_enable;
	assign result.write_data   = side_s2.write_data;
	assign result.stack_access = side_s2.stack_access;
	assign result.stack_offset = side_s2.stack_offset;
	assign result.branch_taken = side_s2.branch_taken;
	assign result.acc_out      = arch_q.a;
	assign result.x_out        = arch_q.x;
	assign result.y_out        = arch_q.y;
	assign result.status_out   = c8ex_pkg::pack_status(arch_q.flags);

	// Checks
	`C8EX_ASSERT_NEXT(a_state_hold, !advance, $stable(arch_q),
		"registers changed without an operation entering the result stage")
	`C8EX_ASSERT_NEXT(a_push_sp, advance && (item_s1.cmd == c8ex_pkg::CMD_PHA ||
		item_s1.cmd == c8ex_pkg::CMD_PHP), arch_q.sp == $past(arch_q.sp) - 8'd1,
		"push did not decrement the stack pointer")
	`C8EX_ASSERT_NOW(a_wd_zero, v_s2 && !side_s2.write_enable, side_s2.write_data == 8'h00,
		"write data nonzero without a write")
	`C8EX_ASSERT_NOW(a_soff_zero, v_s2 && !side_s2.stack_access,
		side_s2.stack_offset == 8'h00, "stack offset nonzero without a stack access")

endmodule
